// ----- rtl/phr_pkg.sv -----
// Shared types and constants for the plate heat relaxation unit.
// No dependencies; the RTL files that use it refer to it by scoped names, the testbench files import it.
package phr_pkg;

   localparam int GRID_ROWS_DEF = 6;
   localparam int GRID_COLS_DEF = 8;

   localparam int DATA_W     = 32;
   localparam int SUM_W      = DATA_W + 2;
   localparam int TOL_W      = 31;
   localparam int CNT_W      = 16;
   localparam int IDX_W      = 4;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [TOL_W-1:0] TOL_RESET   = TOL_W'(655);
   localparam logic [CNT_W-1:0] LIMIT_RESET = '1;

   typedef enum logic [2:0] {
      REG_TOP    = 3'd0,
      REG_RIGHT  = 3'd1,
      REG_BOTTOM = 3'd2,
      REG_LEFT   = 3'd3,
      REG_TOL    = 3'd4,
      REG_LIMIT  = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      NB_UP    = 3'd0,
      NB_LEFT  = 3'd1,
      NB_RIGHT = 3'd2,
      NB_DOWN  = 3'd3,
      NB_CTR   = 3'd4
   } nb_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_temp;
      logic signed [DATA_W-1:0] right_temp;
      logic signed [DATA_W-1:0] bottom_temp;
      logic signed [DATA_W-1:0] left_temp;
      logic [TOL_W-1:0]         change_tolerance;
      logic [CNT_W-1:0]         sweep_limit;
   } cfg_type;

   typedef struct packed {
      logic   init_start;
      logic   pos_first;
      logic   next_full;
      logic   next_inner;
      logic   init_we;
      logic   rd_en;
      nb_type rd_sel;
      logic   wb;
      logic   clear_large;
      logic   sweep_clr;
      logic   sweep_inc;
      logic   limited_we;
      logic   limited_val;
      logic   out_load;
   } cmd_type;

   typedef struct packed {
      logic last_full;
      logic last_inner;
      logic big_change;
      logic limit_hit;
   } status_type;

endpackage

// ----- rtl/phr_if.sv -----
// Handshake channel interfaces for the start item and the result items.
// Depends on phr_pkg for field widths.
interface phr_req_if;
   logic valid;
   logic ready;
   logic start_request;

   modport source (output valid, output start_request, input ready);
   modport sink   (input valid, input start_request, output ready);
endinterface

interface phr_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [phr_pkg::IDX_W-1:0]         cell_row;
   logic [phr_pkg::IDX_W-1:0]         cell_col;
   logic signed [phr_pkg::DATA_W-1:0] cell_temp;
   logic [phr_pkg::CNT_W-1:0]         sweeps_used;
   logic                              hit_limit;
   logic                              last_cell;

   modport source (output valid, output cell_row, output cell_col, output cell_temp,
                   output sweeps_used, output hit_limit, output last_cell, input ready);
   modport sink   (input valid, input cell_row, input cell_col, input cell_temp,
                   input sweeps_used, input hit_limit, input last_cell, output ready);
endinterface

// ----- rtl/phr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module phr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/phr_datapath.sv -----
// Datapath: grid RAM, cell position counters, neighbour accumulator,
// change check, sweep counter and result register. Uses phr_pkg, phr_ram.
module phr_datapath #(
   parameter int GRID_ROWS = phr_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = phr_pkg::GRID_COLS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  phr_pkg::cfg_type    cfg,
   input  phr_pkg::cmd_type    cmd,
   output phr_pkg::status_type st,
   output logic [phr_pkg::IDX_W-1:0]         cell_row,
   output logic [phr_pkg::IDX_W-1:0]         cell_col,
   output logic signed [phr_pkg::DATA_W-1:0] cell_temp,
   output logic [phr_pkg::CNT_W-1:0]         sweeps_used,
   output logic                              hit_limit,
   output logic                              last_cell
);

   localparam int DEPTH  = GRID_ROWS * GRID_COLS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int RW     = $clog2(GRID_ROWS);
   localparam int CW     = $clog2(GRID_COLS);
   localparam int DW     = phr_pkg::DATA_W;
   localparam int SW     = phr_pkg::SUM_W;

   logic [RW-1:0] r_ff, r_in;
   logic [CW-1:0] c_ff, c_in;

   logic [ADDR_W-1:0] base;
   logic [ADDR_W-1:0] raddr;
   logic [DW-1:0]     rdata;
   logic [DW-1:0]     wdata;
   logic              we;
   logic signed [DW-1:0] load_val;

   logic               rd_vld_ff;
   phr_pkg::nb_type    rd_sel_ff;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [DW-1:0] old_ff;
   logic signed [DW-1:0] nv;
   logic signed [DW:0]   diff;
   logic [DW-1:0]        diff_ff;
   logic                 chk_ff;
   logic                 large_ff;
   logic                 diff_big;

   logic [phr_pkg::CNT_W-1:0] sweep_ff;
   logic                      limited_ff;

   logic [phr_pkg::IDX_W-1:0]  row_q_ff, col_q_ff;
   logic signed [DW-1:0]       temp_q_ff;
   logic                       last_q_ff;

   // position counters
   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      if (cmd.init_start) begin
         r_in = '0;
         c_in = '0;
      end else if (cmd.pos_first) begin
         r_in = RW'(1);
         c_in = CW'(1);
      end else if (cmd.next_full) begin
         if (c_ff == CW'(GRID_COLS - 1)) begin
            c_in = '0;
            r_in = r_ff + RW'(1);
         end else begin
            c_in = c_ff + CW'(1);
         end
      end else if (cmd.next_inner) begin
         if (c_ff == CW'(GRID_COLS - 2)) begin
            c_in = CW'(1);
            r_in = r_ff + RW'(1);
         end else begin
            c_in = c_ff + CW'(1);
         end
      end
   end

   assign base = ADDR_W'(r_ff) * ADDR_W'(GRID_COLS) + ADDR_W'(c_ff);

   always_comb begin
      case (cmd.rd_sel)
         phr_pkg::NB_UP:    raddr = base - ADDR_W'(GRID_COLS);
         phr_pkg::NB_DOWN:  raddr = base + ADDR_W'(GRID_COLS);
         phr_pkg::NB_LEFT:  raddr = base - ADDR_W'(1);
         phr_pkg::NB_RIGHT: raddr = base + ADDR_W'(1);
         default:           raddr = base;
      endcase
   end

   always_comb begin
      if (r_ff == '0) begin
         load_val = cfg.top_temp;
      end else if (r_ff == RW'(GRID_ROWS - 1)) begin
         load_val = cfg.bottom_temp;
      end else if (c_ff == '0) begin
         load_val = cfg.left_temp;
      end else if (c_ff == CW'(GRID_COLS - 1)) begin
         load_val = cfg.right_temp;
      end else begin
         load_val = '0;
      end
   end

   assign nv    = sum_ff[SW-1:2];
   assign we    = cmd.init_we | cmd.wb;
   assign wdata = cmd.init_we ? load_val : nv;

   phr_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock (clock),
      .we    (we),
      .waddr (base),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // neighbour sum, one read a cycle
   always_comb begin
      sum_in = sum_ff;
      if (rd_vld_ff) begin
         case (rd_sel_ff)
            phr_pkg::NB_UP:  sum_in = SW'(signed'(rdata));
            phr_pkg::NB_CTR: sum_in = sum_ff;
            default:         sum_in = sum_ff + SW'(signed'(rdata));
         endcase
      end
   end

   assign diff     = {old_ff[DW-1], old_ff} - {nv[DW-1], nv};
   assign diff_big = chk_ff && (diff_ff > DW'(cfg.change_tolerance));

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff       <= '0;
         c_ff       <= '0;
         rd_vld_ff  <= 1'b0;
         rd_sel_ff  <= phr_pkg::NB_UP;
         chk_ff     <= 1'b0;
         large_ff   <= 1'b0;
         sweep_ff   <= '0;
         limited_ff <= 1'b0;
      end else begin
         r_ff      <= r_in;
         c_ff      <= c_in;
         rd_vld_ff <= cmd.rd_en;
         rd_sel_ff <= cmd.rd_sel;
         if (cmd.clear_large) begin
            chk_ff   <= 1'b0;
            large_ff <= 1'b0;
         end else begin
            chk_ff   <= cmd.wb;
            large_ff <= large_ff | diff_big;
         end
         if (cmd.sweep_clr) begin
            sweep_ff <= '0;
         end else if (cmd.sweep_inc) begin
            sweep_ff <= sweep_ff + phr_pkg::CNT_W'(1);
         end
         if (cmd.limited_we) begin
            limited_ff <= cmd.limited_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (rd_vld_ff && rd_sel_ff == phr_pkg::NB_CTR) begin
         old_ff <= rdata;
      end
      if (cmd.wb) begin
         diff_ff <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
      end
      if (cmd.out_load) begin
         row_q_ff  <= phr_pkg::IDX_W'(r_ff);
         col_q_ff  <= phr_pkg::IDX_W'(c_ff);
         temp_q_ff <= rdata;
         last_q_ff <= st.last_inner;
      end
   end

   assign st.last_full  = (r_ff == RW'(GRID_ROWS - 1)) && (c_ff == CW'(GRID_COLS - 1));
   assign st.last_inner = (r_ff == RW'(GRID_ROWS - 2)) && (c_ff == CW'(GRID_COLS - 2));
   assign st.big_change = large_ff | diff_big;
   assign st.limit_hit  = sweep_ff >= cfg.sweep_limit;

   assign cell_row    = row_q_ff;
   assign cell_col    = col_q_ff;
   assign cell_temp   = temp_q_ff;
   assign sweeps_used = sweep_ff;
   assign hit_limit   = limited_ff;
   assign last_cell   = last_q_ff;

endmodule

// ----- rtl/phr_ctrl.sv -----
// Controller: sequences grid load, relaxation sweeps and result readout.
// Uses phr_pkg; drives the datapath by command struct.
module phr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_start,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  phr_pkg::status_type dp_st,
   output phr_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_INIT, S_READ, S_LAST, S_WB, S_DECIDE, S_ORD, S_OLOAD, S_OWAIT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] step_ff, step_in;
   logic       req_ready_ff, req_ready_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      req_ready_in = req_ready_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      cmd.rd_sel   = phr_pkg::NB_CTR;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff && req_start) begin
               cmd.init_start = 1'b1;
               req_ready_in   = 1'b0;
               state_in       = S_INIT;
            end
         end
         S_INIT: begin
            cmd.init_we = 1'b1;
            if (dp_st.last_full) begin
               cmd.pos_first   = 1'b1;
               cmd.clear_large = 1'b1;
               cmd.sweep_clr   = 1'b1;
               step_in         = '0;
               state_in        = S_READ;
            end else begin
               cmd.next_full = 1'b1;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            case (step_ff)
               3'd0:    cmd.rd_sel = phr_pkg::NB_UP;
               3'd1:    cmd.rd_sel = phr_pkg::NB_LEFT;
               3'd2:    cmd.rd_sel = phr_pkg::NB_RIGHT;
               3'd3:    cmd.rd_sel = phr_pkg::NB_DOWN;
               default: cmd.rd_sel = phr_pkg::NB_CTR;
            endcase
            if (step_ff == 3'd4) begin
               state_in = S_LAST;
            end
            step_in = step_ff + 3'd1;
         end
         S_LAST: begin
            state_in = S_WB;
         end
         S_WB: begin
            cmd.wb  = 1'b1;
            step_in = '0;
            if (dp_st.last_inner) begin
               cmd.sweep_inc = 1'b1;
               state_in      = S_DECIDE;
            end else begin
               cmd.next_inner = 1'b1;
               state_in       = S_READ;
            end
         end
         S_DECIDE: begin
            cmd.pos_first = 1'b1;
            if (!dp_st.big_change) begin
               cmd.limited_we  = 1'b1;
               cmd.limited_val = 1'b0;
               state_in        = S_ORD;
            end else if (dp_st.limit_hit) begin
               cmd.limited_we  = 1'b1;
               cmd.limited_val = 1'b1;
               state_in        = S_ORD;
            end else begin
               cmd.clear_large = 1'b1;
               state_in        = S_READ;
            end
         end
         S_ORD: begin
            cmd.rd_en = 1'b1;
            state_in  = S_OLOAD;
         end
         S_OLOAD: begin
            cmd.out_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_OWAIT;
         end
         S_OWAIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (dp_st.last_inner) begin
                  req_ready_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  cmd.next_inner = 1'b1;
                  state_in       = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         req_ready_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         req_ready_ff <= req_ready_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !req_ready_ff)
      else $error("result pending while start is accepted");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready_ff && req_start) |=> !req_ready_ff)
      else $error("still ready after a start item");

   a_run_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && dp_st.last_inner) |=> (req_ready_ff && !rsp_valid_ff))
      else $error("not idle after the final item");

endmodule

// ----- rtl/plate_heat_relaxation_unit.sv -----
// Plate heat relaxation unit, top level: CSR bank, controller, datapath.
// Depends on phr_pkg, phr_if, phr_ram, phr_datapath, phr_ctrl.
//
// Usage: write the boundary temperatures, tolerance and sweep limit over the
// APB port while idle, then send one item on req_ch. An item with
// start_request high loads the grid (one RAM write per cell) and runs
// Gauss-Seidel sweeps; one with it low is taken and dropped. Each sweep
// makes five reads through the single read port of the grid RAM, a settle
// and a write-back per cell. After the final sweep the interior cells leave
// on rsp_ch in row order; each is read out only after the receiver has
// taken the one before. last_cell marks the final one.
// req_ch.ready is low from a start until the final item is taken. A stalled
// receiver holds the item in the output register and pauses readout.
// Reset returns to idle, ready high, CSRs at their reset values.
module plate_heat_relaxation_unit #(
   parameter int GRID_ROWS = phr_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = phr_pkg::GRID_COLS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   phr_req_if.sink                            req_ch,
   phr_rsp_if.source                          rsp_ch,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [phr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [phr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [phr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready
);

   phr_pkg::cfg_type    cfg_ff;
   phr_pkg::cmd_type    cmd;
   phr_pkg::status_type st;
   logic                csr_wr;
   logic [2:0]          csr_idx;

   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[4:2];
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.top_temp         <= '0;
         cfg_ff.right_temp       <= '0;
         cfg_ff.bottom_temp      <= '0;
         cfg_ff.left_temp        <= '0;
         cfg_ff.change_tolerance <= phr_pkg::TOL_RESET;
         cfg_ff.sweep_limit      <= phr_pkg::LIMIT_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            phr_pkg::REG_TOP:    cfg_ff.top_temp         <= pwdata;
            phr_pkg::REG_RIGHT:  cfg_ff.right_temp       <= pwdata;
            phr_pkg::REG_BOTTOM: cfg_ff.bottom_temp      <= pwdata;
            phr_pkg::REG_LEFT:   cfg_ff.left_temp        <= pwdata;
            phr_pkg::REG_TOL:    cfg_ff.change_tolerance <= pwdata[phr_pkg::TOL_W-1:0];
            phr_pkg::REG_LIMIT:  cfg_ff.sweep_limit      <= pwdata[phr_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         phr_pkg::REG_TOP:    prdata = cfg_ff.top_temp;
         phr_pkg::REG_RIGHT:  prdata = cfg_ff.right_temp;
         phr_pkg::REG_BOTTOM: prdata = cfg_ff.bottom_temp;
         phr_pkg::REG_LEFT:   prdata = cfg_ff.left_temp;
         phr_pkg::REG_TOL:    prdata = phr_pkg::CSR_DATA_W'(cfg_ff.change_tolerance);
         phr_pkg::REG_LIMIT:  prdata = phr_pkg::CSR_DATA_W'(cfg_ff.sweep_limit);
         default:             prdata = '0;
      endcase
   end

   phr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_start (req_ch.start_request),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_st     (st),
      .cmd       (cmd)
   );

   phr_datapath #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .st          (st),
      .cell_row    (rsp_ch.cell_row),
      .cell_col    (rsp_ch.cell_col),
      .cell_temp   (rsp_ch.cell_temp),
      .sweeps_used (rsp_ch.sweeps_used),
      .hit_limit   (rsp_ch.hit_limit),
      .last_cell   (rsp_ch.last_cell)
   );

endmodule

// ----- tb/phr_relax_checker.sv -----
`timescale 1ns / 1ps
// Watches the CSR port and both channels of the plate heat relaxation unit,
// relaxes its own copy of the plate on each start item and compares cells.
// Depends on phr_pkg and the channel interfaces in phr_if.
module phr_relax_checker #(
   parameter int GRID_ROWS = phr_pkg::GRID_ROWS_DEF,
   parameter int GRID_COLS = phr_pkg::GRID_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   phr_req_if                             req_mon,
   phr_rsp_if                             rsp_mon,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [phr_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [phr_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic                           pready,
   output int                             mismatch_count,
   output int                             cells_pending
);
   import phr_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] temp;
      logic [CNT_W-1:0]         sweeps;
      logic                     hit_limit;
      logic                     last_cell;
   } cell_type;

   cfg_type                  plate_cfg;
   logic signed [DATA_W-1:0] plate [GRID_ROWS][GRID_COLS];
   cell_type                 predicted_cells [$];
   cell_type                 oldest;

   initial begin
      mismatch_count = 0;
      cells_pending  = 0;
   end

   // load the plate, sweep in place until settled or out of sweeps, queue the cells
   task automatic relax_plate();
      int       r;
      int       c;
      int       sweeps;
      bit       big_change;
      bit       limited;
      longint   sum;
      longint   diff;
      cell_type cell_item;
      logic signed [DATA_W-1:0] nv;
      for (r = 0; r < GRID_ROWS; r++) begin
         for (c = 0; c < GRID_COLS; c++) begin
            if (r == 0) plate[r][c] = plate_cfg.top_temp;
            else if (r == GRID_ROWS - 1) plate[r][c] = plate_cfg.bottom_temp;
            else if (c == 0) plate[r][c] = plate_cfg.left_temp;
            else if (c == GRID_COLS - 1) plate[r][c] = plate_cfg.right_temp;
            else plate[r][c] = '0;
         end
      end
      sweeps  = 0;
      limited = 0;
      do begin
         big_change = 0;
         for (r = 1; r < GRID_ROWS - 1; r++) begin
            for (c = 1; c < GRID_COLS - 1; c++) begin
               sum = longint'(plate[r-1][c]) + longint'(plate[r][c+1])
                   + longint'(plate[r+1][c]) + longint'(plate[r][c-1]);
               nv = DATA_W'(sum >>> 2);
               diff = longint'(plate[r][c]) - longint'(nv);
               if (diff < 0) diff = -diff;
               plate[r][c] = nv;
               if (diff > longint'(plate_cfg.change_tolerance)) big_change = 1;
            end
         end
         sweeps++;
         if (big_change && sweeps >= plate_cfg.sweep_limit) limited = 1;
      end while (big_change && !limited);
      for (r = 1; r < GRID_ROWS - 1; r++) begin
         for (c = 1; c < GRID_COLS - 1; c++) begin
            cell_item.row       = IDX_W'(r);
            cell_item.col       = IDX_W'(c);
            cell_item.temp      = plate[r][c];
            cell_item.sweeps    = CNT_W'(sweeps);
            cell_item.hit_limit = limited;
            cell_item.last_cell = (r == GRID_ROWS - 2) && (c == GRID_COLS - 2);
            predicted_cells.push_back(cell_item);
         end
      end
   endtask

   function automatic void check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         plate_cfg                  = '0;
         plate_cfg.change_tolerance = TOL_RESET;
         plate_cfg.sweep_limit      = LIMIT_RESET;
         predicted_cells.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_reg_type'(paddr[CSR_ADDR_W-1:2]))
               REG_TOP:    plate_cfg.top_temp         = pwdata;
               REG_RIGHT:  plate_cfg.right_temp       = pwdata;
               REG_BOTTOM: plate_cfg.bottom_temp      = pwdata;
               REG_LEFT:   plate_cfg.left_temp        = pwdata;
               REG_TOL:    plate_cfg.change_tolerance = pwdata[TOL_W-1:0];
               REG_LIMIT:  plate_cfg.sweep_limit      = pwdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready && req_mon.start_request) relax_plate();
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (predicted_cells.size() == 0) begin
               $error("cell item row %0d col %0d with none expected",
                      rsp_mon.cell_row, rsp_mon.cell_col);
               mismatch_count++;
            end else begin
               oldest = predicted_cells.pop_front();
               check_field("cell_row", oldest.row, rsp_mon.cell_row);
               check_field("cell_col", oldest.col, rsp_mon.cell_col);
               check_field("cell_temp", oldest.temp, rsp_mon.cell_temp);
               check_field("sweeps_used", oldest.sweeps, rsp_mon.sweeps_used);
               check_field("hit_limit", oldest.hit_limit, rsp_mon.hit_limit);
               check_field("last_cell", oldest.last_cell, rsp_mon.last_cell);
            end
         end
      end
      cells_pending = predicted_cells.size();
   end

endmodule

// ----- tb/tb_plate_heat_relaxation_unit.sv -----
`timescale 1ns / 1ps
// Top of the plate heat relaxation testbench: clock, reset, CSR phases and
// start items with random idling; cells are checked by phr_relax_checker.
// Depends on phr_pkg, phr_if, the unit itself and phr_relax_checker.
module tb_plate_heat_relaxation_unit;
   import phr_pkg::*;

   localparam int START_ITEMS   = 140;
   localparam int CALM_ITEMS    = 20;
   localparam int SETTLE_CYCLES = 20;
   localparam logic [31:0] TEMP_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] TEMP_MIN = 32'h8000_0000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;
   int                    mismatch_count;
   int                    cells_pending;
   bit                    idle_en = 1'b1;
   int                    random_starts;
   int                    burst;
   logic [31:0]           tol_word;
   logic [31:0]           limit_word;

   phr_req_if req_ch ();
   phr_rsp_if rsp_ch ();

   plate_heat_relaxation_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   phr_relax_checker u_relax_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .pready         (pready),
      .mismatch_count (mismatch_count),
      .cells_pending  (cells_pending)
   );

   always #1 clock = ~clock;

   initial begin
      #30_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver stalls in short bursts
   initial begin
      rsp_ch.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (idle_en && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end
         rsp_ch.ready = 1'b1;
      end
   end

   task automatic csr_write(input csr_reg_type idx, input logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   task automatic set_plate(input logic [31:0] top, input logic [31:0] right,
                            input logic [31:0] bottom, input logic [31:0] left,
                            input logic [31:0] tol, input logic [31:0] limit);
      csr_write(REG_TOP, top);
      csr_write(REG_RIGHT, right);
      csr_write(REG_BOTTOM, bottom);
      csr_write(REG_LEFT, left);
      csr_write(REG_TOL, tol);
      csr_write(REG_LIMIT, limit);
   endtask

   // valid stays high across back-to-back items; a gap lowers it first
   task automatic send_start(input logic start);
      @(negedge clock);
      if (idle_en && $urandom_range(0, 3) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_ch.valid         = 1'b1;
      req_ch.start_request = start;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (cells_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_temp();
      case ($urandom_range(0, 5))
         0:       return TEMP_MAX;
         1:       return TEMP_MIN;
         2:       return 32'h0;
         3:       return $urandom_range(0, 32'h00FF_FFFF);
         4:       return -$urandom_range(0, 32'h00FF_FFFF);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_ch.valid         = 1'b0;
      req_ch.start_request = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: cold plate settles in one sweep; a non-start item is dropped
      send_start(1'b0);
      send_start(1'b1);
      wait_drained();
      // settles on the only sweep allowed
      set_plate(32'h0, 32'h0, 32'h0, 32'h0, 32'd655, 32'd1);
      send_start(1'b1);
      wait_drained();
      set_plate(TEMP_MAX, TEMP_MAX, TEMP_MAX, TEMP_MAX, 32'd655, 32'h0000_FFFF);
      send_start(1'b1);
      wait_drained();
      set_plate(TEMP_MIN, TEMP_MIN, TEMP_MIN, TEMP_MIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_start(1'b1);
      send_start(1'b1);
      wait_drained();
      // zero limit acts as one; corners follow top and bottom
      set_plate(TEMP_MAX, 32'h0001_0000, TEMP_MIN, 32'hFFFF_FFFF, 32'h8000_0000, 32'hABCD_0000);
      send_start(1'b1);
      send_start(1'b1);
      wait_drained();
      set_plate(32'h0064_0000, 32'h0, 32'h0032_0000, 32'hFFCE_0000, 32'h0, 32'd1);
      send_start(1'b1);
      wait_drained();
      set_plate(32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 32'h0004_0000, 32'h0, 32'd200);
      send_start(1'b1);
      wait_drained();
      set_plate(TEMP_MIN, TEMP_MAX, TEMP_MAX, TEMP_MIN, 32'd655, 32'd3);
      send_start(1'b1);
      send_start(1'b0);
      send_start(1'b1);
      wait_drained();

      random_starts = 0;
      while (random_starts < START_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       tol_word = $urandom_range(0, 255);
            1:       tol_word = $urandom_range(256, 65535);
            2:       tol_word = $urandom_range(0, 32'h7FFF_FFFF);
            default: tol_word = 32'd655;
         endcase
         case ($urandom_range(0, 7))
            0:       limit_word = 32'd0;
            1:       limit_word = 32'd1;
            2: begin
               limit_word = 32'h0000_FFFF;
               tol_word   = $urandom_range(4096, 32'h7FFF_FFFF);
            end
            default: limit_word = $urandom_range(2, 48);
         endcase
         tol_word[31]       = 1'($urandom_range(0, 1));
         limit_word[31:16]  = 16'($urandom_range(0, 16'hFFFF));
         set_plate(pick_temp(), pick_temp(), pick_temp(), pick_temp(), tol_word, limit_word);
         burst = $urandom_range(1, 6);
         repeat (burst) begin
            if ($urandom_range(0, 5) == 0) send_start(1'b0);
            send_start(1'b1);
            random_starts++;
            if (random_starts >= START_ITEMS - CALM_ITEMS) idle_en = 1'b0;
            if ($urandom_range(0, 9) == 0) wait_drained();
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && cells_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
